// ===== src/su3pt_pkg.sv =====
// Shared types and constants for the SU(3) plaquette trace block.
// Used by the controller, the datapath and the top level; no dependencies.
package su3pt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_LAT_B,
        ST_MUL,
        ST_XWAIT,
        ST_STORE,
        ST_TRACE,
        ST_TWAIT,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    // link codes as carried in which_link
    localparam logic [1:0] LINK_U1 = 2'd0;
    localparam logic [1:0] LINK_U2 = 2'd1;
    localparam logic [1:0] LINK_U3 = 2'd2;
    localparam logic [1:0] LINK_U4 = 2'd3;
    localparam logic [1:0] ROW_LAST = 2'd2;

    // multiplier operand selects
    localparam logic [1:0] MUL_RR = 2'd0;
    localparam logic [1:0] MUL_II = 2'd1;
    localparam logic [1:0] MUL_RI = 2'd2;
    localparam logic [1:0] MUL_IR = 2'd3;

    localparam logic STAGE_ENTRY = 1'b0;
    localparam logic STAGE_TRACE = 1'b1;

    typedef struct packed {
        logic       start;
        logic       lat_a;
        logic       lat_b;
        logic [1:0] col;
        logic       conj;
        logic       mul_en;
        logic       stage;
        logic [1:0] mul_sel;
        logic       store;
        logic       store_y;
        logic       scale;
        logic       div_step;
        logic       finish;
    } cmd_t;

endpackage

// ===== src/su3pt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module su3pt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== src/su3pt_ctrl.sv =====
// Sequencer for the plaquette trace: walks rows, columns and products.
// Depends on su3pt_pkg; drives the link RAM addresses and datapath commands.
module su3pt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_link,
    input  logic [1:0]       in_row,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             ram_we,
    output logic [3:0]       ram_waddr,
    output logic [3:0]       ram_raddr,
    output su3pt_pkg::cmd_t  cmd
);

    su3pt_pkg::state_t state_reg, state_next;
    logic [1:0]      i_reg, k_reg, j_reg, step_reg;
    logic            pass_reg;
    logic            out_valid_reg;
    logic            accept, trigger, out_free;
    logic [1:0]      link_a, link_b;

    assign accept   = in_valid && in_ready;
    assign trigger  = accept && in_link == su3pt_pkg::LINK_U4 && in_row == su3pt_pkg::ROW_LAST;
    assign out_free = !out_valid_reg || out_ready;
    // pass 0 forms U1 U2, pass 1 forms the daggered product from links 3 and 2
    assign link_a   = pass_reg ? su3pt_pkg::LINK_U4 : su3pt_pkg::LINK_U1;
    assign link_b   = pass_reg ? su3pt_pkg::LINK_U3 : su3pt_pkg::LINK_U2;
    assign out_valid = out_valid_reg;

    assign ram_we    = accept && in_row <= su3pt_pkg::ROW_LAST;
    assign ram_waddr = 4'(in_link) * 4'd3 + 4'(in_row);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            su3pt_pkg::ST_IDLE:   if (trigger) state_next = su3pt_pkg::ST_RD_A;
            su3pt_pkg::ST_RD_A:   state_next = su3pt_pkg::ST_RD_B;
            su3pt_pkg::ST_RD_B:   state_next = su3pt_pkg::ST_LAT_B;
            su3pt_pkg::ST_LAT_B:  state_next = su3pt_pkg::ST_MUL;
            su3pt_pkg::ST_MUL:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = (j_reg == 2'd2) ? su3pt_pkg::ST_XWAIT : su3pt_pkg::ST_RD_A;
                end
            end
            su3pt_pkg::ST_XWAIT:  state_next = su3pt_pkg::ST_STORE;
            su3pt_pkg::ST_STORE:
            begin
                state_next = pass_reg ? su3pt_pkg::ST_TRACE : su3pt_pkg::ST_RD_A;
            end
            su3pt_pkg::ST_TRACE:
            begin
                if (step_reg[0])
                begin
                    state_next = (i_reg == 2'd2 && k_reg == 2'd2) ?
                                 su3pt_pkg::ST_TWAIT : su3pt_pkg::ST_RD_A;
                end
            end
            su3pt_pkg::ST_TWAIT:  state_next = su3pt_pkg::ST_SCALE;
            su3pt_pkg::ST_SCALE:  state_next = su3pt_pkg::ST_DIV;
            su3pt_pkg::ST_DIV:    state_next = su3pt_pkg::ST_DONE;
            su3pt_pkg::ST_DONE:   if (out_free) state_next = su3pt_pkg::ST_IDLE;
            default:              state_next = su3pt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        ram_raddr = 4'(link_a) * 4'd3 + 4'(i_reg);
        case (state_reg)
            su3pt_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = trigger;
            end
            su3pt_pkg::ST_RD_A:
            begin
                ram_raddr = 4'(link_a) * 4'd3 + 4'(i_reg);
            end
            su3pt_pkg::ST_RD_B:
            begin
                ram_raddr = 4'(link_b) * 4'd3 + 4'(j_reg);
                cmd.lat_a = 1'b1;
                cmd.col   = j_reg;
                cmd.conj  = pass_reg;
            end
            su3pt_pkg::ST_LAT_B:
            begin
                cmd.lat_b = 1'b1;
                cmd.col   = k_reg;
                cmd.conj  = pass_reg;
            end
            su3pt_pkg::ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.stage   = su3pt_pkg::STAGE_ENTRY;
                cmd.mul_sel = step_reg;
            end
            su3pt_pkg::ST_STORE:
            begin
                cmd.store   = 1'b1;
                cmd.store_y = pass_reg;
            end
            su3pt_pkg::ST_TRACE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.stage   = su3pt_pkg::STAGE_TRACE;
                cmd.mul_sel = step_reg[0] ? su3pt_pkg::MUL_II : su3pt_pkg::MUL_RR;
            end
            su3pt_pkg::ST_SCALE:  cmd.scale = 1'b1;
            su3pt_pkg::ST_DIV:    cmd.div_step = 1'b1;
            su3pt_pkg::ST_DONE:   cmd.finish = out_free;
            default:              cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= su3pt_pkg::ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                su3pt_pkg::ST_IDLE:
                begin
                    i_reg    <= '0;
                    k_reg    <= '0;
                    j_reg    <= '0;
                    step_reg <= '0;
                    pass_reg <= 1'b0;
                end
                su3pt_pkg::ST_MUL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                    end
                end
                su3pt_pkg::ST_STORE:
                begin
                    pass_reg <= !pass_reg;
                    step_reg <= '0;
                end
                su3pt_pkg::ST_TRACE:
                begin
                    step_reg <= {1'b0, !step_reg[0]};
                    if (step_reg[0])
                    begin
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= '0;
                            i_reg <= i_reg + 2'd1;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                end
                default:              ;
            endcase
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/su3pt_dp.sv =====
// Datapath: shared complex-product multiplier, accumulators, scaling,
// divide by three and the saturating totals. Depends on su3pt_pkg.
module su3pt_dp #(
    parameter int ENTRY_WIDTH = 16,
    parameter int SUM_WIDTH   = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  su3pt_pkg::cmd_t               cmd,
    input  logic [6*ENTRY_WIDTH-1:0]      rd_data,
    output logic signed [ENTRY_WIDTH-1:0] plaq_value,
    output logic signed [SUM_WIDTH-1:0]   running_sum,
    output logic [COUNT_WIDTH-1:0]        plaq_count
);

    localparam int EW  = ENTRY_WIDTH;
    localparam int SW  = SUM_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int F   = EW - 2;
    localparam int H   = (EW > 26) ? EW - 26 : 0;
    localparam int D   = F - 2 * H;
    localparam int XW0 = EW + 4;                    // one entry of U1 U2, exact
    localparam int XW  = XW0 - H;                   // same after pre-shift
    localparam int MW  = (XW > EW + 1) ? XW : EW + 1;
    localparam int PW  = 2 * MW;
    localparam int TW  = 2 * XW + 5;                // trace sum of 18 products
    localparam int DK  = EW + 3;                    // reciprocal scale for divide by three
    localparam int QW  = 2 * EW + 5;

    localparam logic signed [PW:0]  RND_F  = (PW + 1)'(1) << (F - 1);
    localparam logic signed [XW0:0] HALF_H = (H > 0) ?
        ((XW0 + 1)'(1) << ((H > 0) ? H - 1 : 0)) : '0;
    localparam logic signed [TW:0]  BIAS_D = (TW + 1)'(3) << (D - 1);
    localparam logic signed [TW:0]  CLAMP  = (TW + 1)'(3) << (EW - 1);
    localparam logic [DK-1:0]       RECIP  = DK'(((64'd1 << DK) + 64'd2) / 64'd3);

    logic signed [EW-1:0] row_re [3];
    logic signed [EW-1:0] row_im [3];

    logic signed [EW:0]    a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [EW:0]    lat_re, lat_im;
    logic signed [XW-1:0]  x_re_reg, x_im_reg, y_re_reg, y_im_reg;
    logic signed [XW0-1:0] acc_re_reg, acc_im_reg;
    logic signed [XW-1:0]  acc_re_h, acc_im_h;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  prod_reg;
    logic                  acc_en_reg, acc_stage_reg;
    logic [1:0]            acc_sel_reg;
    logic signed [PW:0]    term_w;
    logic signed [XW0-1:0] term;
    logic signed [TW-1:0]  t_reg, tprod;
    logic signed [TW:0]    scaled, clamped, shifted;
    logic [EW+1:0]         num_reg, quo_reg;
    logic [QW-1:0]         quo_prod;
    logic signed [EW-1:0]  pv_calc, pv_reg;
    logic signed [SW:0]    sum_w;
    logic signed [SW-1:0]  sum_reg;
    logic [CW-1:0]         cnt_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_cols
        assign row_re[c] = rd_data[2 * c * EW +: EW];
        assign row_im[c] = rd_data[(2 * c + 1) * EW +: EW];
    end

    // conjugation is applied at the operand, before rounding
    assign lat_re = (EW + 1)'(row_re[cmd.col]);
    assign lat_im = cmd.conj ? -(EW + 1)'(row_im[cmd.col]) : (EW + 1)'(row_im[cmd.col]);

    always_comb
    begin
        mul_a = MW'(a_re_reg);
        mul_b = MW'(b_re_reg);
        if (cmd.stage == su3pt_pkg::STAGE_TRACE)
        begin
            mul_a = (cmd.mul_sel == su3pt_pkg::MUL_II) ? MW'(x_im_reg) : MW'(x_re_reg);
            mul_b = (cmd.mul_sel == su3pt_pkg::MUL_II) ? MW'(y_im_reg) : MW'(y_re_reg);
        end
        else
        begin
            case (cmd.mul_sel)
                su3pt_pkg::MUL_RR: begin mul_a = MW'(a_re_reg); mul_b = MW'(b_re_reg); end
                su3pt_pkg::MUL_II: begin mul_a = MW'(a_im_reg); mul_b = MW'(b_im_reg); end
                su3pt_pkg::MUL_RI: begin mul_a = MW'(a_re_reg); mul_b = MW'(b_im_reg); end
                su3pt_pkg::MUL_IR: begin mul_a = MW'(a_im_reg); mul_b = MW'(b_re_reg); end
                default:           begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign term_w   = (PW + 1)'(prod_reg) + RND_F;
    assign term     = XW0'(term_w >>> F);
    assign tprod    = TW'(prod_reg);
    assign acc_re_h = XW'(((XW0 + 1)'(acc_re_reg) + HALF_H) >>> H);
    assign acc_im_h = XW'(((XW0 + 1)'(acc_im_reg) + HALF_H) >>> H);

    // floor((t + 1.5 * 2^D) / 2^D), clamped so the divide by three saturates correctly
    assign scaled  = ((TW + 1)'(t_reg) + BIAS_D) >>> D;
    assign clamped = (scaled > CLAMP) ? CLAMP : ((scaled < -CLAMP) ? -CLAMP : scaled);
    assign shifted = clamped + CLAMP;

    // divide by three as a multiply by ceil(2^DK / 3), exact below 2^(EW+2)
    assign quo_prod = QW'(num_reg) * QW'(RECIP);

    // quotient is offset by 2^(EW-1); top value 2^EW saturates
    assign pv_calc = (quo_reg[EW+1:EW] != 2'b00) ? {1'b0, {(EW - 1){1'b1}}}
                                                  : {~quo_reg[EW-1], quo_reg[EW-2:0]};
    assign sum_w   = (SW + 1)'(sum_reg) + (SW + 1)'(pv_calc);

    always_ff @(posedge clk)
    begin
        if (cmd.lat_a)
        begin
            a_re_reg <= lat_re;
            a_im_reg <= lat_im;
        end
        if (cmd.lat_b)
        begin
            b_re_reg <= lat_re;
            b_im_reg <= lat_im;
        end
        if (cmd.mul_en)
        begin
            prod_reg      <= PW'(mul_a * mul_b);
            acc_stage_reg <= cmd.stage;
            acc_sel_reg   <= cmd.mul_sel;
        end

        if (cmd.start || cmd.store)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (acc_en_reg && acc_stage_reg == su3pt_pkg::STAGE_ENTRY)
        begin
            case (acc_sel_reg)
                su3pt_pkg::MUL_RR: acc_re_reg <= acc_re_reg + term;
                su3pt_pkg::MUL_II: acc_re_reg <= acc_re_reg - term;
                default:           acc_im_reg <= acc_im_reg + term;
            endcase
        end

        if (cmd.start)
        begin
            t_reg <= '0;
        end
        else if (acc_en_reg && acc_stage_reg == su3pt_pkg::STAGE_TRACE)
        begin
            t_reg <= (acc_sel_reg == su3pt_pkg::MUL_II) ? t_reg - tprod : t_reg + tprod;
        end

        if (cmd.store)
        begin
            if (cmd.store_y)
            begin
                y_re_reg <= acc_re_h;
                y_im_reg <= acc_im_h;
            end
            else
            begin
                x_re_reg <= acc_re_h;
                x_im_reg <= acc_im_h;
            end
        end

        if (cmd.scale)
        begin
            num_reg <= shifted[EW+1:0];
        end
        if (cmd.div_step)
        begin
            quo_reg <= quo_prod[DK +: EW + 2];
        end

        if (cmd.finish)
        begin
            pv_reg <= pv_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            acc_en_reg <= cmd.mul_en;
            if (cmd.finish)
            begin
                if (sum_w[SW] != sum_w[SW-1])
                begin
                    sum_reg <= sum_w[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
                end
                else
                begin
                    sum_reg <= sum_w[SW-1:0];
                end
                if (cnt_reg != {CW{1'b1}})
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    assign plaq_value  = pv_reg;
    assign running_sum = sum_reg;
    assign plaq_count  = cnt_reg;

endmodule

// ===== src/su3_plaquette_trace.sv =====
// Top level of the SU(3) plaquette trace block: stream ports, link RAM,
// sequencer and datapath. Depends on su3pt_pkg, su3pt_ram, su3pt_ctrl, su3pt_dp.

// Each input transfer carries one row of one link matrix; the rows are kept in
// a 12-row link RAM. Row 2 of link 3 starts the plaquette evaluation, which
// ends when the result is registered: one shared multiplier forms each of the
// 216 real partial products of U1 U2 and U3+ U4+ and the 18 of the trace, with
// the operands fetched row by row through the RAM's single read port, and a
// reciprocal multiply does the divide by three.
// No input is taken during the evaluation; other rows are taken one per cycle,
// also while a result waits on the output register. Rows with index 3 are
// dropped. The running sum and the count restart only at reset.
module su3_plaquette_trace #(
    parameter int ENTRY_WIDTH = 16,
    parameter int SUM_WIDTH   = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // e0_re, e0_im, e1_re, e1_im, e2_re, e2_im
    input  logic [((6*ENTRY_WIDTH+7)/8)*8-1:0]               s_tdata,
    // which_link, row_index
    input  logic [3:0]                                       s_tuser,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // plaq_value, running_sum, plaq_count
    output logic [((ENTRY_WIDTH+SUM_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int ROW_W  = 6 * ENTRY_WIDTH;
    localparam int OUT_DW = ((ENTRY_WIDTH + SUM_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

    su3pt_pkg::cmd_t cmd;
    logic                          ram_we;
    logic [3:0]                    ram_waddr, ram_raddr;
    logic [ROW_W-1:0]              rd_data;
    logic signed [ENTRY_WIDTH-1:0] plaq_value;
    logic signed [SUM_WIDTH-1:0]   running_sum;
    logic [COUNT_WIDTH-1:0]        plaq_count;

    su3pt_ram #(
        .WIDTH(ROW_W),
        .DEPTH(12)
    ) u_link_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_tdata[ROW_W-1:0]),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    su3pt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_link  (s_tuser[1:0]),
        .in_row   (s_tuser[3:2]),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_raddr(ram_raddr),
        .cmd      (cmd)
    );

    su3pt_dp #(
        .ENTRY_WIDTH(ENTRY_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_data    (rd_data),
        .plaq_value (plaq_value),
        .running_sum(running_sum),
        .plaq_count (plaq_count)
    );

    assign m_tdata = OUT_DW'({plaq_count, running_sum, plaq_value});

    // the link RAM is written only by an accepted transfer
    a_write_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s_tvalid && s_tready))
        else $error("link RAM written without an input transfer");

    // a new result always follows an evaluation, during which input is held off
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised without an evaluation");

    // every result counts at least one plaquette
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (plaq_count != '0))
        else $error("result presented with a zero plaquette count");

endmodule
